// ===== hw/rtl/nearest_scale_overlay_compositor_top_macros.svh =====
// Assertion macros for the compositor top module.
`ifndef NEAREST_SCALE_OVERLAY_COMPOSITOR_TOP_MACROS_SVH
`define NEAREST_SCALE_OVERLAY_COMPOSITOR_TOP_MACROS_SVH
// Same-cycle implication, clocked on clk_i and disabled during reset.
`define NSOC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, clocked on clk_i and disabled during reset.
`define NSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/nsoc_pkg.sv =====
// Types and constants shared by the overlay compositor modules.
package nsoc_pkg;

  localparam int unsigned MAX_EYE_WIDTH  = 1024;
  localparam int unsigned MAX_EYE_HEIGHT = 1024;
  localparam int unsigned MAX_FRAME_DIM  = 4096;

  localparam int unsigned POS_W     = 12;
  localparam int unsigned COL_W     = 8;
  localparam int unsigned REG_W     = 13;
  localparam int unsigned EYE_REG_W = 11;
  localparam int unsigned GEO_W     = 14;
  localparam int unsigned PROD_W    = POS_W + EYE_REG_W;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd7;

  localparam logic [COL_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [GEO_W-1:0] MIN_EXTENT   = 14'd2;
  localparam logic             REQ_LOAD     = 1'b0;

  typedef struct packed {
    logic             req_type;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [COL_W-1:0] in_blue;
    logic [COL_W-1:0] in_green;
    logic [COL_W-1:0] in_red;
    logic [COL_W-1:0] in_alpha;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] out_blue;
    logic [COL_W-1:0] out_green;
    logic [COL_W-1:0] out_red;
    logic [COL_W-1:0] out_alpha;
    logic             from_eye;
  } out_t;

  typedef struct packed {
    logic [REG_W-1:0]     base_width;
    logic [REG_W-1:0]     base_height;
    logic [EYE_REG_W-1:0] eye_width;
    logic [EYE_REG_W-1:0] eye_height;
    logic [REG_W-1:0]     target_left;
    logic [REG_W-1:0]     target_top;
    logic [REG_W-1:0]     target_width;
    logic [REG_W-1:0]     target_height;
  } cfg_t;

  // Clamped target extents, the divisors of the scaler.
  typedef struct packed {
    logic [GEO_W-1:0] tw;
    logic [GEO_W-1:0] th;
  } geo_t;

  // Per-word sideband that travels down the pipeline.
  // hit: taken from the eye for a pixel, inside the store for a load.
  typedef struct packed {
    logic             is_pixel;
    logic             hit;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [COL_W-1:0] blue;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] alpha;
  } side_t;

endpackage

// ===== hw/rtl/nsoc_front.sv =====
// Front end: rectangle clamping, hit test, offsets and scale products.
module nsoc_front #(
  parameter int unsigned MaxEyeWidth  = nsoc_pkg::MAX_EYE_WIDTH,
  parameter int unsigned MaxEyeHeight = nsoc_pkg::MAX_EYE_HEIGHT,
  parameter int unsigned MaxFrameDim  = nsoc_pkg::MAX_FRAME_DIM
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  nsoc_pkg::in_t                      data_i,
  input  nsoc_pkg::cfg_t                     cfg_i,
  output nsoc_pkg::geo_t                     geo_o,
  output logic                               valid_o,
  output nsoc_pkg::side_t                    side_o,
  output logic [nsoc_pkg::PROD_W-1:0]        num_x_o,
  output logic [nsoc_pkg::PROD_W-1:0]        num_y_o
);

  localparam int unsigned GW = nsoc_pkg::GEO_W;
  localparam int unsigned EW = nsoc_pkg::EYE_REG_W + 1;

  logic [GW-1:0] bw, bh, left, top, right_raw, bottom_raw, right, bottom, tw, th;
  logic [GW-1:0] px, py;
  logic          sizes_ok, in_rect, load_ok;
  nsoc_pkg::side_t side_d;

  // Clamp the frame and the rectangle to the frame.
  always_comb begin
    bw = ({1'b0, cfg_i.base_width} > GW'(MaxFrameDim)) ? GW'(MaxFrameDim)
                                                        : {1'b0, cfg_i.base_width};
    bh = ({1'b0, cfg_i.base_height} > GW'(MaxFrameDim)) ? GW'(MaxFrameDim)
                                                         : {1'b0, cfg_i.base_height};
    left = ({1'b0, cfg_i.target_left} < bw) ? {1'b0, cfg_i.target_left} : bw;
    top  = ({1'b0, cfg_i.target_top} < bh) ? {1'b0, cfg_i.target_top} : bh;
    right_raw  = {1'b0, cfg_i.target_left} + {1'b0, cfg_i.target_width};
    bottom_raw = {1'b0, cfg_i.target_top} + {1'b0, cfg_i.target_height};
    right  = (right_raw < bw) ? right_raw : bw;
    bottom = (bottom_raw < bh) ? bottom_raw : bh;
    tw = (right > left) ? right - left : '0;
    th = (bottom > top) ? bottom - top : '0;
  end

  assign geo_o = '{tw: tw, th: th};

  // Decide per word whether it takes the eye or lands in the store.
  always_comb begin
    px = GW'(data_i.pos_x);
    py = GW'(data_i.pos_y);
    sizes_ok = (bw >= nsoc_pkg::MIN_EXTENT) && (bh >= nsoc_pkg::MIN_EXTENT) &&
               (GW'(cfg_i.eye_width) >= nsoc_pkg::MIN_EXTENT) &&
               (GW'(cfg_i.eye_height) >= nsoc_pkg::MIN_EXTENT) &&
               ({1'b0, cfg_i.eye_width} <= EW'(MaxEyeWidth)) &&
               ({1'b0, cfg_i.eye_height} <= EW'(MaxEyeHeight)) &&
               (tw >= nsoc_pkg::MIN_EXTENT) && (th >= nsoc_pkg::MIN_EXTENT);
    in_rect = (px < bw) && (py < bh) && (px >= left) && (px < right) &&
              (py >= top) && (py < bottom);
    load_ok = (px < GW'(MaxEyeWidth)) && (py < GW'(MaxEyeHeight));
    side_d.is_pixel = (data_i.req_type != nsoc_pkg::REQ_LOAD);
    side_d.hit = side_d.is_pixel ? (sizes_ok && in_rect) : load_ok;
    side_d.pos_x = data_i.pos_x;
    side_d.pos_y = data_i.pos_y;
    side_d.blue  = data_i.in_blue;
    side_d.green = data_i.in_green;
    side_d.red   = data_i.in_red;
    side_d.alpha = data_i.in_alpha;
  end

  logic                       va_q, vb_q;
  nsoc_pkg::side_t            sa_q, sb_q;
  logic [nsoc_pkg::POS_W-1:0] dxa_q, dya_q;
  logic [nsoc_pkg::PROD_W-1:0] nx_q, ny_q;
  logic [GW-1:0]              dx_full, dy_full;

  assign dx_full = px - left;
  assign dy_full = py - top;

  // Stage A: offsets into the rectangle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q  <= side_d;
      dxa_q <= dx_full[nsoc_pkg::POS_W-1:0];
      dya_q <= dy_full[nsoc_pkg::POS_W-1:0];
      // Stage B: scale products offset times eye size.
      sb_q  <= sa_q;
      nx_q  <= nsoc_pkg::PROD_W'(dxa_q) * nsoc_pkg::PROD_W'(cfg_i.eye_width);
      ny_q  <= nsoc_pkg::PROD_W'(dya_q) * nsoc_pkg::PROD_W'(cfg_i.eye_height);
    end
  end

  assign valid_o = vb_q;
  assign side_o  = sb_q;
  assign num_x_o = nx_q;
  assign num_y_o = ny_q;

endmodule

// ===== hw/rtl/nsoc_div.sv =====
// Pipelined restoring dividers for both axes, one quotient bit per stage.
module nsoc_div #(
  parameter int unsigned QuoW = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  nsoc_pkg::side_t              side_i,
  input  logic [nsoc_pkg::PROD_W-1:0]  num_x_i,
  input  logic [nsoc_pkg::PROD_W-1:0]  num_y_i,
  input  nsoc_pkg::geo_t               geo_i,
  output logic                         valid_o,
  output nsoc_pkg::side_t              side_o,
  output logic [QuoW-1:0]              quo_x_o,
  output logic [QuoW-1:0]              quo_y_o
);

  localparam int unsigned NW = nsoc_pkg::PROD_W;
  localparam int unsigned SW = NW + nsoc_pkg::GEO_W + QuoW;

  logic            v   [QuoW+1];
  nsoc_pkg::side_t s   [QuoW+1];
  logic [NW-1:0]   rx  [QuoW+1];
  logic [NW-1:0]   ry  [QuoW+1];
  logic [QuoW-1:0] qx  [QuoW+1];
  logic [QuoW-1:0] qy  [QuoW+1];

  assign v[0]  = valid_i;
  assign s[0]  = side_i;
  assign rx[0] = num_x_i;
  assign ry[0] = num_y_i;
  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int unsigned B = QuoW - 1 - k;
    logic [SW-1:0]   dx_sh, dy_sh;
    logic            ge_x, ge_y;
    logic [NW-1:0]   rx_d, ry_d;
    logic [QuoW-1:0] qx_d, qy_d;

    // Try to subtract the divisor shifted to this quotient bit.
    always_comb begin
      dx_sh = SW'(geo_i.tw) << B;
      dy_sh = SW'(geo_i.th) << B;
      ge_x  = SW'(rx[k]) >= dx_sh;
      ge_y  = SW'(ry[k]) >= dy_sh;
      rx_d  = ge_x ? NW'(SW'(rx[k]) - dx_sh) : rx[k];
      ry_d  = ge_y ? NW'(SW'(ry[k]) - dy_sh) : ry[k];
      qx_d  = qx[k] | (ge_x ? (QuoW'(1) << B) : '0);
      qy_d  = qy[k] | (ge_y ? (QuoW'(1) << B) : '0);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s[k+1]  <= s[k];
        rx[k+1] <= rx_d;
        ry[k+1] <= ry_d;
        qx[k+1] <= qx_d;
        qy[k+1] <= qy_d;
      end
    end
  end

  assign valid_o = v[QuoW];
  assign side_o  = s[QuoW];
  assign quo_x_o = qx[QuoW];
  assign quo_y_o = qy[QuoW];

endmodule

// ===== hw/rtl/nsoc_store.sv =====
// Eye image store with write on load words, registered read, result select.
module nsoc_store #(
  parameter int unsigned XW = 10,
  parameter int unsigned YW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  nsoc_pkg::side_t  side_i,
  input  logic [XW-1:0]    sx_i,
  input  logic [YW-1:0]    sy_i,
  output logic             out_valid_o,
  output nsoc_pkg::out_t   out_data_o
);

  localparam int unsigned AW = XW + YW;
  localparam int unsigned PW = 3 * nsoc_pkg::COL_W;

  logic [PW-1:0]   mem [2**AW];
  logic [PW-1:0]   rd_q;
  logic            v_q;
  nsoc_pkg::side_t s_q;
  logic [AW-1:0]   wr_addr, rd_addr;

  assign wr_addr = {side_i.pos_y[YW-1:0], side_i.pos_x[XW-1:0]};
  assign rd_addr = {sy_i, sx_i};

  // Loads write in program order with pixel reads at this stage.
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i && !side_i.is_pixel && side_i.hit) begin
      mem[wr_addr] <= {side_i.red, side_i.green, side_i.blue};
    end
    if (en_i) begin
      rd_q <= mem[rd_addr];
      s_q  <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  // Only pixel words produce a result.
  assign out_valid_o = v_q && s_q.is_pixel;

  always_comb begin
    if (s_q.hit) begin
      out_data_o.out_blue  = rd_q[nsoc_pkg::COL_W-1:0];
      out_data_o.out_green = rd_q[2*nsoc_pkg::COL_W-1:nsoc_pkg::COL_W];
      out_data_o.out_red   = rd_q[PW-1:2*nsoc_pkg::COL_W];
      out_data_o.out_alpha = nsoc_pkg::ALPHA_OPAQUE;
      out_data_o.from_eye  = 1'b1;
    end else begin
      out_data_o.out_blue  = s_q.blue;
      out_data_o.out_green = s_q.green;
      out_data_o.out_red   = s_q.red;
      out_data_o.out_alpha = s_q.alpha;
      out_data_o.from_eye  = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/nearest_scale_overlay_compositor_top.sv =====
// Each word passes front stages A and B, the divider stages and the registered store read.
// Throughput: one word per cycle unless stalled; one quotient bit per divider stage.
// The whole pipeline advances together and holds only while a result waits at the output.
// Reset clears the configuration registers and all valid bits; the eye store is not cleared.
// Eye store contents are undefined until written by load words.
module nearest_scale_overlay_compositor_top #(
  parameter int unsigned MaxEyeWidth  = nsoc_pkg::MAX_EYE_WIDTH,
  parameter int unsigned MaxEyeHeight = nsoc_pkg::MAX_EYE_HEIGHT,
  parameter int unsigned MaxFrameDim  = nsoc_pkg::MAX_FRAME_DIM
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  nsoc_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output nsoc_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nsoc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nsoc_pkg::REG_W-1:0]      cfg_data_i
);

`include "nearest_scale_overlay_compositor_top_macros.svh"

  localparam int unsigned XW   = $clog2(MaxEyeWidth);
  localparam int unsigned YW   = $clog2(MaxEyeHeight);
  localparam int unsigned QuoW = (XW > YW) ? XW : YW;

  nsoc_pkg::cfg_t cfg_q;
  logic           en;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nsoc_pkg::CFG_BASE_WIDTH:    cfg_q.base_width    <= cfg_data_i;
        nsoc_pkg::CFG_BASE_HEIGHT:   cfg_q.base_height   <= cfg_data_i;
        nsoc_pkg::CFG_EYE_WIDTH:
          cfg_q.eye_width  <= cfg_data_i[nsoc_pkg::EYE_REG_W-1:0];
        nsoc_pkg::CFG_EYE_HEIGHT:
          cfg_q.eye_height <= cfg_data_i[nsoc_pkg::EYE_REG_W-1:0];
        nsoc_pkg::CFG_TARGET_LEFT:   cfg_q.target_left   <= cfg_data_i;
        nsoc_pkg::CFG_TARGET_TOP:    cfg_q.target_top    <= cfg_data_i;
        nsoc_pkg::CFG_TARGET_WIDTH:  cfg_q.target_width  <= cfg_data_i;
        nsoc_pkg::CFG_TARGET_HEIGHT: cfg_q.target_height <= cfg_data_i;
        default:                     cfg_q <= cfg_q;
      endcase
    end
  end

  // The pipeline moves unless a finished word waits at the output.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  nsoc_pkg::geo_t              geo;
  logic                        fr_valid, dv_valid;
  nsoc_pkg::side_t             fr_side, dv_side;
  logic [nsoc_pkg::PROD_W-1:0] num_x, num_y;
  logic [QuoW-1:0]             quo_x, quo_y;

  nsoc_front #(
    .MaxEyeWidth  (MaxEyeWidth),
    .MaxEyeHeight (MaxEyeHeight),
    .MaxFrameDim  (MaxFrameDim)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .geo_o   (geo),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .num_x_o (num_x),
    .num_y_o (num_y)
  );

  nsoc_div #(
    .QuoW (QuoW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .num_x_i (num_x),
    .num_y_i (num_y),
    .geo_i   (geo),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  nsoc_store #(
    .XW (XW),
    .YW (YW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (dv_valid),
    .side_i      (dv_side),
    .sx_i        (quo_x[XW-1:0]),
    .sy_i        (quo_y[YW-1:0]),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Checks on the pipeline control and the scaler.
  `NSOC_ASSERT(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i, "stall without a waiting result")
  `NSOC_ASSERT(a_eye_opaque, out_valid_o && out_data_o.from_eye, out_data_o.out_alpha == nsoc_pkg::ALPHA_OPAQUE, "eye pixel not opaque")
  `NSOC_ASSERT(a_src_x_range, dv_valid && dv_side.is_pixel && dv_side.hit, (nsoc_pkg::EYE_REG_W + 1)'(quo_x) < (nsoc_pkg::EYE_REG_W + 1)'(cfg_q.eye_width), "source column beyond eye width")
  `NSOC_ASSERT(a_src_y_range, dv_valid && dv_side.is_pixel && dv_side.hit, (nsoc_pkg::EYE_REG_W + 1)'(quo_y) < (nsoc_pkg::EYE_REG_W + 1)'(cfg_q.eye_height), "source row beyond eye height")
  `NSOC_ASSERT_NEXT(a_stall_freezes, !in_ready_o, $stable(quo_x) && $stable(dv_valid), "divider moved during a stall")

endmodule
